// ----- sv/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// shared constants and types of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int PLE_CAPACITY   = 64;
  localparam int PLE_DATA_WIDTH = 32;

  // operation kinds
  localparam logic [2:0] KIND_INSERT    = 3'd0;
  localparam logic [2:0] KIND_REMOVE_AT = 3'd1;
  localparam logic [2:0] KIND_REMOVE_VAL = 3'd2;
  localparam logic [2:0] KIND_CLEAR     = 3'd3;
  localparam logic [2:0] KIND_READ_ALL  = 3'd4;

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_BADPOS   = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  // result handed from the sequencer to the output stage
  typedef struct packed {
    logic        load;
    logic [31:0] value;
    logic        last;
    logic [6:0]  size;
    logic [2:0]  status;
  } ple_res_t;

endpackage

// ----- sv/positional_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_core
// ordered list of up to CAPACITY words held in one synchronous memory
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_kind, in_position, in_item_value.
// An item is taken when in_valid is high and in_stall low; in_stall is high
// while an operation is in progress, one operation at a time.
// Result channel: out_valid/out_stall with out_value, out_last,
// out_list_size, out_status, from an output register. Every kind gives one
// result, but read all of a non-empty list gives one per entry (last flagged).
// Steps per item, with one read and one write port on the entry memory:
//   insert at position p: entries from p up move one place up, then the word goes in
//   append: the word is written; remove at position p: later entries move down
//   remove value: every entry is read; clear and unknown kinds: no memory walk
//   read all: one entry per cycle with an idle receiver
// A stall on the result channel holds the output register and pauses read
// all; the next item can be taken while the final result still waits.
// Reset empties the list at once; entries are only read below the count.
// ----------------------------------------------------------------------------
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int CAPACITY   = PLE_CAPACITY,
  parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic signed [7:0] in_position,
  input  logic [31:0]       in_item_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_value,
  output logic              out_last,
  output logic [6:0]        out_list_size,
  output logic [2:0]        out_status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  out_free;
  ple_res_t              res;

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ple_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_free      (out_free),
    .res           (res)
  );

  ple_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_last      (out_last),
    .out_list_size (out_list_size),
    .out_status    (out_status)
  );

endmodule

// ----- sv/ple_ram.sv -----
// ----------------------------------------------------------------------------
// ple_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/ple_out.sv -----
// ----------------------------------------------------------------------------
// ple_out
// output register of the result channel
// ----------------------------------------------------------------------------
module ple_out
  import ple_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ple_res_t    res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_last,
  output logic [6:0]  out_list_size,
  output logic [2:0]  out_status
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] value_r;
  logic        last_r;
  logic [6:0]  size_r;
  logic [2:0]  status_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = res.load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      value_r  <= res.value;
      last_r   <= res.last;
      size_r   <= res.size;
      status_r <= res.status;
    end
  end

  assign out_valid     = valid_r;
  assign out_value     = value_r;
  assign out_last      = last_r;
  assign out_list_size = size_r;
  assign out_status    = status_r;

endmodule

// ----- sv/ple_seq.sv -----
// ----------------------------------------------------------------------------
// ple_seq
// operation sequencer: walks the entry memory to shift, search and read out
// ----------------------------------------------------------------------------
module ple_seq
  import ple_pkg::*;
#(
  parameter int CAPACITY   = PLE_CAPACITY,
  parameter int DATA_WIDTH = PLE_DATA_WIDTH,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_kind,
  input  logic signed [7:0]     in_position,
  input  logic [31:0]           in_item_value,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data,
  input  logic                  out_free,
  output ple_res_t              res
);

  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_REM   = 5'b00100,
    S_RDALL = 5'b01000,
    S_RESP  = 5'b10000
  } ple_state_t;

  ple_state_t            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]         stop_idx_r, stop_idx_nxt;
  logic                  rd_more_r, rd_more_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         addr_d_r, addr_d_nxt;
  logic                  found_r, found_nxt;
  logic                  by_pos_r, by_pos_nxt;
  logic [2:0]            status_r, status_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;

  logic                      issue;
  logic                      cons;
  logic                      done_walk;
  logic [DATA_WIDTH+31:0]    in_ext;
  logic [DATA_WIDTH+31:0]    rd_ext;
  logic [CW+6:0]             size_ext;
  logic [CMPW-1:0]           pos_cmp;
  logic [CMPW-1:0]           cnt_cmp;
  logic                      pos_neg;
  logic [AW-1:0]             cnt_m1;

  assign in_ext   = {{DATA_WIDTH{1'b0}}, in_item_value};
  assign rd_ext   = {32'b0, rd_data};
  assign size_ext = {7'b0, count_r};
  assign pos_cmp  = CMPW'(in_position[6:0]);
  assign cnt_cmp  = CMPW'(count_r);
  assign pos_neg  = in_position[7];
  assign cnt_m1   = AW'(count_r - 1'b1);

  assign in_stall  = (state_r != S_IDLE);
  assign done_walk = !rd_more_r && !pend_r;

  // read data is taken at once when shifting, only when the output has room on read out
  always_comb begin
    cons = pend_r;
    if (state_r == S_RDALL) begin
      cons = pend_r && out_free;
    end
  end

  always_comb begin
    issue = 1'b0;
    case (state_r)
      S_INS, S_REM: issue = rd_more_r;
      S_RDALL:      issue = rd_more_r && (!pend_r || cons);
      default:      issue = 1'b0;
    endcase
  end

  assign rd_en   = issue;
  assign rd_addr = rd_idx_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    stop_idx_nxt = stop_idx_r;
    rd_more_nxt  = rd_more_r;
    found_nxt    = found_r;
    by_pos_nxt   = by_pos_r;
    status_nxt   = status_r;
    word_nxt     = word_r;
    pend_nxt     = issue || (pend_r && !cons);
    addr_d_nxt   = issue ? rd_idx_r : addr_d_r;
    wr_en        = 1'b0;
    wr_addr      = addr_d_r;
    wr_data      = rd_data;
    res          = '0;

    if (issue) begin
      if (state_r == S_INS) begin
        rd_idx_nxt = rd_idx_r - 1'b1;
      end else begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
      if (rd_idx_r == stop_idx_r) begin
        rd_more_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          word_nxt    = in_ext[DATA_WIDTH-1:0];
          status_nxt  = STAT_OK;
          found_nxt   = 1'b0;
          rd_more_nxt = 1'b0;
          state_nxt   = S_RESP;
          case (in_kind)
            KIND_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                status_nxt = STAT_FULL;
              end else begin
                rd_idx_nxt = cnt_m1;
                if (!pos_neg && pos_cmp < cnt_cmp) begin
                  stop_idx_nxt = AW'(in_position[6:0]);
                  rd_more_nxt  = 1'b1;
                end else begin
                  stop_idx_nxt = AW'(count_r);
                end
                state_nxt = S_INS;
              end
            end
            KIND_REMOVE_AT: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (pos_neg || pos_cmp >= cnt_cmp) begin
                status_nxt = STAT_BADPOS;
              end else begin
                rd_idx_nxt   = AW'(in_position[6:0]);
                stop_idx_nxt = cnt_m1;
                rd_more_nxt  = 1'b1;
                by_pos_nxt   = 1'b1;
                state_nxt    = S_REM;
              end
            end
            KIND_REMOVE_VAL: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                rd_idx_nxt   = '0;
                stop_idx_nxt = cnt_m1;
                rd_more_nxt  = 1'b1;
                by_pos_nxt   = 1'b0;
                state_nxt    = S_REM;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            KIND_READ_ALL: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                rd_idx_nxt   = '0;
                stop_idx_nxt = cnt_m1;
                rd_more_nxt  = 1'b1;
                state_nxt    = S_RDALL;
              end
            end
            default: begin
              status_nxt = STAT_OK;
            end
          endcase
        end
      end

      S_INS: begin
        if (pend_r) begin
          // move entry one place up
          wr_en   = 1'b1;
          wr_addr = AW'(addr_d_r + 1'b1);
          wr_data = rd_data;
        end else if (!rd_more_r) begin
          wr_en     = 1'b1;
          wr_addr   = stop_idx_r;
          wr_data   = word_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_REM: begin
        if (pend_r) begin
          if (found_r) begin
            // close the gap
            wr_en   = 1'b1;
            wr_addr = AW'(addr_d_r - 1'b1);
            wr_data = rd_data;
          end else if (by_pos_r || rd_data == word_r) begin
            found_nxt = 1'b1;
          end
        end else if (done_walk) begin
          if (found_r) begin
            count_nxt  = count_r - 1'b1;
            status_nxt = STAT_OK;
          end else begin
            status_nxt = STAT_NOTFOUND;
          end
          state_nxt = S_RESP;
        end
      end

      S_RDALL: begin
        res.load   = cons;
        res.value  = rd_ext[31:0];
        res.last   = (addr_d_r == stop_idx_r);
        res.size   = size_ext[6:0];
        res.status = STAT_OK;
        if (done_walk) begin
          state_nxt = S_IDLE;
        end
      end

      S_RESP: begin
        res.load   = out_free;
        res.value  = '0;
        res.last   = 1'b1;
        res.size   = size_ext[6:0];
        res.status = status_r;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_more_r <= 1'b0;
      pend_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_more_r <= rd_more_nxt;
      pend_r    <= pend_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    stop_idx_r <= stop_idx_nxt;
    addr_d_r   <= addr_d_nxt;
    by_pos_r   <= by_pos_nxt;
    status_r   <= status_nxt;
    word_r     <= word_nxt;
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// positional list engine: a short table of directed operations (empty list,
// extreme positions and words, every kind, unused kinds), then random mixes,
// a fill past capacity under a long result hold-off, and a stretch without
// idling; results are checked against the table or a shadow list in the bench
// ----------------------------------------------------------------------------
module testbench;
  import ple_pkg::*;

  localparam int CAPACITY    = PLE_CAPACITY;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 80;
  localparam int N_DIR       = 25;

  // kinds with no operation behind them
  localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic [6:0]  size;
    logic [2:0]  status;
  } list_result_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pos;
    logic [31:0] word;
    logic        typed;
    logic [6:0]  size;
    logic [2:0]  status;
  } op_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_kind = KIND_CLEAR;
  logic signed [7:0] in_position = 8'sd0;
  logic [31:0]       in_item_value = 32'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       out_value;
  logic              out_last;
  logic [6:0]        out_list_size;
  logic [2:0]        out_status;

  logic [31:0]  shadow_words [CAPACITY];
  int           shadow_count = 0;
  list_result_t op_results [$];
  list_result_t pending_results [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int full_drops     = 0;
  int quiet_cycles   = 0;
  bit idle_on        = 1'b1;
  int hold_ticket    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stall_left     = 0;

  op_row_t dir_rows [0:N_DIR-1] = '{
    '{KIND_READ_ALL,   8'h00, 32'h0000_0000, 1'b1, 7'd0, STAT_EMPTY},
    '{KIND_REMOVE_AT,  8'h00, 32'h0000_0000, 1'b1, 7'd0, STAT_EMPTY},
    '{KIND_REMOVE_VAL, 8'h00, 32'h0000_0000, 1'b1, 7'd0, STAT_EMPTY},
    '{KIND_CLEAR,      8'h00, 32'h0000_0000, 1'b1, 7'd0, STAT_OK},
    '{KIND_UNUSED_5,   8'h00, 32'h0000_0000, 1'b1, 7'd0, STAT_OK},
    '{KIND_UNUSED_6,   8'hFF, 32'hFFFF_FFFF, 1'b1, 7'd0, STAT_OK},
    '{KIND_UNUSED_7,   8'h80, 32'h5555_AAAA, 1'b1, 7'd0, STAT_OK},
    '{KIND_INSERT,     8'h00, 32'h0000_0000, 1'b1, 7'd1, STAT_OK},
    '{KIND_INSERT,     8'h80, 32'hFFFF_FFFF, 1'b1, 7'd2, STAT_OK},
    '{KIND_INSERT,     8'h7F, 32'h8000_0001, 1'b1, 7'd3, STAT_OK},
    '{KIND_INSERT,     8'h01, 32'h1234_5678, 1'b1, 7'd4, STAT_OK},
    '{KIND_INSERT,     8'h04, 32'hA5A5_A5A5, 1'b1, 7'd5, STAT_OK},
    '{KIND_INSERT,     8'h05, 32'hFFFF_FFFF, 1'b1, 7'd6, STAT_OK},
    '{KIND_INSERT,     8'h07, 32'h0000_0000, 1'b1, 7'd7, STAT_OK},
    '{KIND_READ_ALL,   8'h00, 32'h0000_0000, 1'b0, 7'd0, STAT_OK},
    '{KIND_REMOVE_AT,  8'hFF, 32'h0000_0000, 1'b1, 7'd7, STAT_BADPOS},
    '{KIND_REMOVE_AT,  8'h07, 32'h0000_0000, 1'b1, 7'd7, STAT_BADPOS},
    '{KIND_REMOVE_AT,  8'h7F, 32'h0000_0000, 1'b1, 7'd7, STAT_BADPOS},
    '{KIND_REMOVE_VAL, 8'h00, 32'hDEAD_BEEF, 1'b1, 7'd7, STAT_NOTFOUND},
    '{KIND_REMOVE_VAL, 8'h00, 32'hFFFF_FFFF, 1'b1, 7'd6, STAT_OK},
    '{KIND_REMOVE_AT,  8'h00, 32'h0000_0000, 1'b1, 7'd5, STAT_OK},
    '{KIND_REMOVE_AT,  8'h04, 32'h0000_0000, 1'b1, 7'd4, STAT_OK},
    '{KIND_READ_ALL,   8'h00, 32'h0000_0000, 1'b0, 7'd0, STAT_OK},
    '{KIND_CLEAR,      8'h00, 32'h0000_0000, 1'b1, 7'd0, STAT_OK},
    '{KIND_READ_ALL,   8'h00, 32'h0000_0000, 1'b1, 7'd0, STAT_EMPTY}
  };

  positional_list_engine_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_last      (out_last),
    .out_list_size (out_list_size),
    .out_status    (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow list: applies one operation and leaves its results in op_results
  function automatic void apply_list_op(logic [2:0] kind, logic signed [7:0] pos,
                                        logic [31:0] word);
    int           p;
    int           at;
    int           i;
    logic [2:0]   st;
    bit           hit;
    list_result_t r;
    p  = pos;
    st = STAT_OK;
    op_results.delete();
    case (kind)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          st = STAT_FULL;
          full_drops++;
        end else begin
          at = (p >= 0 && p <= shadow_count) ? p : shadow_count;
          for (i = shadow_count; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = word;
          shadow_count++;
        end
      end
      KIND_REMOVE_AT: begin
        if (shadow_count == 0) st = STAT_EMPTY;
        else if (p < 0 || p >= shadow_count) st = STAT_BADPOS;
        else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      KIND_REMOVE_VAL: begin
        if (shadow_count == 0) st = STAT_EMPTY;
        else begin
          st  = STAT_NOTFOUND;
          hit = 1'b0;
          for (i = 0; i < shadow_count && !hit; i++) begin
            if (shadow_words[i] == word) begin
              hit = 1'b1;
              at  = i;
            end
          end
          if (hit) begin
            for (i = at; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
            shadow_count--;
            st = STAT_OK;
          end
        end
      end
      KIND_CLEAR: shadow_count = 0;
      default: ;
    endcase
    if (kind == KIND_READ_ALL && shadow_count > 0) begin
      for (i = 0; i < shadow_count; i++) begin
        r = '{shadow_words[i], i + 1 == shadow_count, 7'(shadow_count), STAT_OK};
        op_results.push_back(r);
      end
    end else begin
      if (kind == KIND_READ_ALL) st = STAT_EMPTY;
      r = '{32'd0, 1'b1, 7'(shadow_count), st};
      op_results.push_back(r);
    end
  endfunction

  task automatic send_item(logic [2:0] kind, logic signed [7:0] pos, logic [31:0] word,
                           bit typed, logic [6:0] size, logic [2:0] status);
    list_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_position   <= pos;
    in_item_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    apply_list_op(kind, pos, word);
    if (typed) begin
      r = '{32'd0, 1'b1, size, status};
      pending_results.push_back(r);
    end else begin
      foreach (op_results[i]) pending_results.push_back(op_results[i]);
    end
    @(negedge clk);
  endtask

  // small words make duplicates, held words make removals hit
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'($urandom_range(0, 7));
    if (r < 55 && shadow_count > 0) return shadow_words[$urandom_range(0, shadow_count - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [7:0] pick_position();
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 55) p = $urandom_range(0, shadow_count);
    else if (r < 75) p = $urandom;
    else if (r < 87) p = -$urandom_range(1, 128);
    else p = shadow_count + $urandom_range(0, 1);
    return p[7:0];
  endfunction

  task automatic send_random_op();
    int         r;
    logic [2:0] kind;
    r = $urandom_range(0, 99);
    if (r < 50) kind = KIND_INSERT;
    else if (r < 64) kind = KIND_REMOVE_AT;
    else if (r < 80) kind = KIND_REMOVE_VAL;
    else if (r < 90) kind = KIND_READ_ALL;
    else if (r < 94) kind = KIND_CLEAR;
    else kind = 3'($urandom_range(KIND_UNUSED_5, KIND_UNUSED_7));
    send_item(kind, pick_position(), pick_word(), 1'b0, 7'd0, STAT_OK);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h want %0h (result %0d)", field, got, want, results_seen);
    mismatch_count++;
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, value", out_value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
        if (out_last !== want.last) report_mismatch("out_last", 32'(out_last), 32'(want.last));
        if (out_list_size !== want.size)
          report_mismatch("out_list_size", 32'(out_list_size), 32'(want.size));
        if (out_status !== want.status)
          report_mismatch("out_status", 32'(out_status), 32'(want.status));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < N_DIR; n++) begin
      send_item(dir_rows[n].kind, dir_rows[n].pos, dir_rows[n].word,
                dir_rows[n].typed, dir_rows[n].size, dir_rows[n].status);
    end
    wait_drained();

    repeat (40) send_random_op();

    // fill past capacity while the result side is held off
    hold_ticket++;
    while (shadow_count < CAPACITY) send_item(KIND_INSERT, pick_position(), pick_word(),
                                              1'b0, 7'd0, STAT_OK);
    repeat (2) send_item(KIND_INSERT, pick_position(), pick_word(), 1'b0, 7'd0, STAT_OK);
    send_item(KIND_READ_ALL, 8'sd0, 32'd0, 1'b0, 7'd0, STAT_OK);
    repeat (4) send_item(KIND_REMOVE_VAL, 8'sd0, pick_word(), 1'b0, 7'd0, STAT_OK);
    send_item(KIND_INSERT, 8'sd0, $urandom, 1'b0, 7'd0, STAT_OK);
    wait_drained();

    repeat (40) send_random_op();

    idle_on = 1'b0;
    repeat (25) send_random_op();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results left over", 32'(pending_results.size()), 32'd0);
    end

    $display("covered %0d items and %0d results, %0d inserts dropped on a full list",
             items_sent, results_seen, full_drops);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
